>>> design/eott_pkg.sv
// Shared types and constants for the expiry-ordered timer table.
package eott_pkg;

	// Table geometry and time range.
	localparam int SLOTS       = 16;
	localparam int TIME_BITS   = 32;
	localparam int MAX_RESULTS = 16;
	localparam int SEQ_BITS    = 32;

	// Derived widths.
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
	localparam int SUM_W  = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [SLOT_W-1:0]    slot_idx_t;
	typedef logic [SEQ_BITS-1:0]  seq_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// Operation codes of a request.
	typedef enum logic [1:0] {
		OP_ARM     = 2'd0,
		OP_DISARM  = 2'd1,
		OP_PROCESS = 2'd2
	} op_t;

	// One result item waiting for the response register.
	typedef struct packed {
		logic       fired;
		logic [3:0] expired_slot;
		logic       last;
	} result_t;

endpackage

>>> design/eott_if.sv
// Valid/ready channel interfaces for timer requests and timer results.
interface eott_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [3:0]  slot;
	logic [31:0] delay_ms;
	logic [31:0] now;

	modport source (output valid, output operation, output slot, output delay_ms,
		output now, input ready);
	modport sink (input valid, input operation, input slot, input delay_ms,
		input now, output ready);
endinterface

interface eott_rsp_if;
	logic       valid;
	logic       ready;
	logic       fired;
	logic [3:0] expired_slot;
	logic       last;

	modport source (output valid, output fired, output expired_slot, output last,
		input ready);
	modport sink (input valid, input fired, input expired_slot, input last,
		output ready);
endinterface

>>> design/expiry_ordered_timer_table.sv
// Expiry-ordered timer table: arm, disarm and process one-shot timers per slot.
// Arm, disarm and unknown operations: the result loads when the output register is free.
// Process: a full scan and a resolve step per fired timer, a closing scan unless the result
// limit is hit, and an emit step per result that waits while the output register is held.
// Nothing due: one scan and resolve step, then the result; no request is taken meanwhile.
// Reset disarms every slot and clears the arm counter; expiry times and stamps stay undefined.
module expiry_ordered_timer_table
	import eott_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	eott_req_if.sink     req,
	eott_rsp_if.source   rsp
);

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_SCAN    = 4'b0010,
		ST_RESOLVE = 4'b0100,
		ST_EMIT    = 4'b1000
	} state_t;

	// Where the sequencer goes once a pending result has moved out.
	typedef enum logic [1:0] {
		AFT_IDLE  = 2'd0,
		AFT_SCAN  = 2'd1,
		AFT_FINAL = 2'd2
	} after_t;

	state_t     state_q;
	after_t     after_q;
	logic [SLOTS-1:0] armed_q;
	time_t      expiry_q [SLOTS];
	seq_t       order_q  [SLOTS];
	seq_t       arm_cnt_q;

	time_t      now_q;
	slot_idx_t  idx_q;
	logic       best_v_q;
	slot_idx_t  best_q;
	time_t      best_exp_q;
	seq_t       best_age_q;
	logic       have_prev_q;
	slot_idx_t  prev_q;
	cnt_t       fired_cnt_q;
	result_t    pend_q;

	logic       out_v_q;
	result_t    out_q;

	logic       req_xfer;
	logic       out_free;
	logic       slot_ok;
	slot_idx_t  req_idx;
	time_t      req_now;
	logic [SUM_W-1:0] arm_sum;
	time_t      arm_exp;
	time_t      scan_exp;
	seq_t       scan_age;
	logic       scan_due;
	logic       scan_better;
	logic       last_idx;
	cnt_t       cnt_next;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign out_free  = !out_v_q || rsp.ready;

	assign rsp.valid        = out_v_q;
	assign rsp.fired        = out_q.fired;
	assign rsp.expired_slot = out_q.expired_slot;
	assign rsp.last         = out_q.last;

	// Request decode and saturating expiry for arm.
	assign slot_ok = (32'(req.slot) < 32'(SLOTS));
	assign req_idx = SLOT_W'(req.slot);
	assign req_now = TIME_BITS'(req.now);
	assign arm_sum = SUM_W'(req_now) + SUM_W'(req.delay_ms);
	assign arm_exp = (arm_sum > SUM_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
		: TIME_BITS'(arm_sum);

	// Shared compare unit: one slot per scan cycle against the best so far.
	// Older arms have a larger age and win ties on equal expiry.
	assign scan_exp    = expiry_q[idx_q];
	assign scan_age    = arm_cnt_q - order_q[idx_q];
	assign scan_due    = armed_q[idx_q] && (scan_exp <= now_q);
	assign scan_better = !best_v_q || (scan_exp < best_exp_q)
		|| ((scan_exp == best_exp_q) && (scan_age > best_age_q));
	assign last_idx    = (idx_q == SLOT_W'(SLOTS - 1));
	assign cnt_next    = fired_cnt_q + cnt_t'(1);

	// Expiry and arm-stamp storage, written on an arm transfer.
	always_ff @(posedge clk) begin
		if (req_xfer && (op_t'(req.operation) == OP_ARM) && slot_ok) begin
			expiry_q[req_idx] <= arm_exp;
			order_q[req_idx]  <= arm_cnt_q;
		end
	end

	// Sequencer, slot flags and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			after_q     <= AFT_IDLE;
			armed_q     <= '0;
			arm_cnt_q   <= '0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
			pend_q      <= '0;
			now_q       <= '0;
			best_v_q    <= 1'b0;
			best_q      <= '0;
			best_exp_q  <= '0;
			best_age_q  <= '0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			fired_cnt_q <= '0;
			idx_q       <= '0;
		end else begin
			// The sequencer loads the next result, or the sink takes the waiting one.
			if ((state_q == ST_EMIT) && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && rsp.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						pend_q  <= '{fired: 1'b0, expired_slot: 4'd0, last: 1'b1};
						after_q <= AFT_IDLE;
						state_q <= (op_t'(req.operation) == OP_PROCESS) ? ST_SCAN : ST_EMIT;
						unique case (op_t'(req.operation))
							OP_ARM: begin
								if (slot_ok) begin
									armed_q[req_idx] <= 1'b1;
									arm_cnt_q        <= arm_cnt_q + seq_t'(1);
								end
							end
							OP_DISARM: begin
								if (slot_ok) begin
									armed_q[req_idx] <= 1'b0;
								end
							end
							OP_PROCESS: begin
								now_q       <= req_now;
								idx_q       <= '0;
								best_v_q    <= 1'b0;
								have_prev_q <= 1'b0;
								fired_cnt_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end

				ST_SCAN: begin
					if (scan_due && scan_better) begin
						best_v_q   <= 1'b1;
						best_q     <= idx_q;
						best_exp_q <= scan_exp;
						best_age_q <= scan_age;
					end
					if (last_idx) begin
						state_q <= ST_RESOLVE;
					end else begin
						idx_q <= idx_q + slot_idx_t'(1);
					end
				end

				ST_RESOLVE: begin
					if (best_v_q) begin
						// Fire the earliest due slot; unless the result limit is reached, hold it back until the
						// next scan shows whether it is the final result.
						armed_q[best_q] <= 1'b0;
						fired_cnt_q     <= cnt_next;
						prev_q          <= best_q;
						have_prev_q     <= 1'b1;
						if (have_prev_q) begin
							pend_q  <= '{fired: 1'b1, expired_slot: 4'(prev_q), last: 1'b0};
							after_q <= (cnt_next == cnt_t'(MAX_RESULTS)) ? AFT_FINAL
								: AFT_SCAN;
							state_q <= ST_EMIT;
						end else if (cnt_next == cnt_t'(MAX_RESULTS)) begin
							pend_q  <= '{fired: 1'b1, expired_slot: 4'(best_q), last: 1'b1};
							after_q <= AFT_IDLE;
							state_q <= ST_EMIT;
						end else begin
							idx_q    <= '0;
							best_v_q <= 1'b0;
							state_q  <= ST_SCAN;
						end
					end else begin
						pend_q  <= '{fired: have_prev_q,
							expired_slot: have_prev_q ? 4'(prev_q) : 4'd0, last: 1'b1};
						after_q <= AFT_IDLE;
						state_q <= ST_EMIT;
					end
				end

				ST_EMIT: begin
					if (out_free) begin
						out_q <= pend_q;
						unique case (after_q)
							AFT_SCAN: begin
								idx_q    <= '0;
								best_v_q <= 1'b0;
								state_q  <= ST_SCAN;
							end
							AFT_FINAL: begin
								pend_q  <= '{fired: 1'b1, expired_slot: 4'(prev_q), last: 1'b1};
								after_q <= AFT_IDLE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
